// ===== rtl/joystick_axis_conditioner_assert.svh =====
// Assertion macros shared by the conditioner's modules.
`ifndef JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH
`ifndef ASSERT_OFF
// An implication or plain property that must hold at every clock edge out of reset.
`define JAC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// A condition that must never be seen at a clock edge out of reset.
`define JAC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define JAC_ASSERT(lbl, clk, rst, prop, msg)
`define JAC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/jac_pkg.sv =====
package jac_pkg;

  // Mounting rotation codes, clockwise.
  typedef enum logic [1:0] {
    ROT_NONE  = 2'd0,
    ROT_CW90  = 2'd1,
    ROT_CW180 = 2'd2,
    ROT_CW270 = 2'd3
  } rot_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 3'd7;

  localparam int DEADZONE_W = 15;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 15'd1638;

  // Queue between front and back holds 2**QUEUE_AW beats.
  localparam int QUEUE_AW = 2;

  // Per-axis classification made by the front.
  typedef struct packed {
    logic is_zero;  // sample equals center
    logic sat;      // quotient reaches full scale or divisor is zero
    logic neg;      // quotient is negative
  } axis_ctl_t;

  localparam int AXIS_CTL_W = $bits(axis_ctl_t);

endpackage

// ===== rtl/joystick_axis_conditioner.sv =====
// Channel   Dir  Fields (lowest bit first)            Handshake
// s_axis    in   tdata: raw_x, raw_y                  s_tvalid / s_tready
// m_axis    out  tdata: norm_x, norm_y; tuser: idle   m_tvalid / m_tready
// cfg       in   index cfg_addr, data cfg_data        cfg_we, no wait
//
// One sample pair per cycle while the output beat is not held; an input beat
// passes through the queue, the bit-per-stage dividers (FRACTION_BITS + 2
// register stages, the first loaded as the queue pops), and the rotation,
// square and output stages.
// Reset is synchronous, clears the queue and the valid pipe, and restores the calibration defaults.
// A held output beat freezes the back pipe; the four-beat queue keeps taking
// input until it fills.
module joystick_axis_conditioner #(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // raw_x, raw_y
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // norm_x, norm_y
  output logic [((2*(FRACTION_BITS+2)+7)/8)*8-1:0] m_tdata,
  // idle
  output logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [jac_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [((SAMPLE_BITS > 15) ? SAMPLE_BITS : 15)-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int NW     = F + 2;
  localparam int OUT_DW = ((2*NW+7)/8)*8;
  localparam int CFG_W  = (SB > 15) ? SB : 15;
  localparam int CW     = jac_pkg::AXIS_CTL_W;
  localparam int QW     = 4*SB + 2*CW;

  logic [SB-1:0]                  f_a_x, f_d_x, f_a_y, f_d_y;
  jac_pkg::axis_ctl_t             f_ctl_x, f_ctl_y;
  jac_pkg::rot_t                  rotation;
  logic [jac_pkg::DEADZONE_W-1:0] deadzone;

  logic [QW-1:0]      q_in, q_out;
  logic               q_valid, q_pop;
  jac_pkg::axis_ctl_t b_ctl_x, b_ctl_y;

  logic signed [NW-1:0] norm_x, norm_y;

  jac_front #(.SB(SB), .CFG_W(CFG_W)) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .raw_x(s_tdata[SB-1:0]), .raw_y(s_tdata[2*SB-1:SB]),
    .a_x(f_a_x), .d_x(f_d_x), .a_y(f_a_y), .d_y(f_d_y),
    .ctl_x(f_ctl_x), .ctl_y(f_ctl_y),
    .rotation(rotation), .deadzone(deadzone)
  );

  // Classified beat layout: a_x, d_x, a_y, d_y, ctl_x, ctl_y from the lowest bit.
  assign q_in = {f_ctl_y, f_ctl_x, f_d_y, f_a_y, f_d_x, f_a_x};

  jac_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(s_tvalid), .push_ready(s_tready), .push_data(q_in),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  assign b_ctl_x = jac_pkg::axis_ctl_t'(q_out[4*SB +: CW]);
  assign b_ctl_y = jac_pkg::axis_ctl_t'(q_out[4*SB+CW +: CW]);

  jac_back #(.SB(SB), .F(F)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop),
    .a_x(q_out[0 +: SB]), .d_x(q_out[SB +: SB]),
    .a_y(q_out[2*SB +: SB]), .d_y(q_out[3*SB +: SB]),
    .ctl_x(b_ctl_x), .ctl_y(b_ctl_y),
    .rotation(rotation), .deadzone(deadzone),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .norm_x(norm_x), .norm_y(norm_y), .idle(m_tuser)
  );

  assign m_tdata = OUT_DW'({norm_y, norm_x});

endmodule

// ===== rtl/jac_front.sv =====
module jac_front #(
  parameter int SB    = 10,
  parameter int CFG_W = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jac_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic [SB-1:0]                 raw_x,
  input  logic [SB-1:0]                 raw_y,
  output logic [SB-1:0]                 a_x,
  output logic [SB-1:0]                 d_x,
  output logic [SB-1:0]                 a_y,
  output logic [SB-1:0]                 d_y,
  output jac_pkg::axis_ctl_t            ctl_x,
  output jac_pkg::axis_ctl_t            ctl_y,
  output jac_pkg::rot_t                 rotation,
  output logic [jac_pkg::DEADZONE_W-1:0] deadzone
);

  logic [SB-1:0] center_x, center_y, min_x, max_x, min_y, max_y;

  logic [SB-1:0]      raw_a [2];
  logic [SB-1:0]      ctr_a [2];
  logic [SB-1:0]      lo_a  [2];
  logic [SB-1:0]      hi_a  [2];
  logic [SB-1:0]      mag_a [2];
  logic [SB-1:0]      div_a [2];
  jac_pkg::axis_ctl_t ctl_a [2];

  // Calibration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= SB'(512);
      center_y <= SB'(512);
      min_x    <= '0;
      max_x    <= SB'(1023);
      min_y    <= '0;
      max_y    <= SB'(1023);
      rotation <= jac_pkg::ROT_NONE;
      deadzone <= jac_pkg::DEADZONE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        jac_pkg::CFG_CENTER_X: center_x <= cfg_data[SB-1:0];
        jac_pkg::CFG_CENTER_Y: center_y <= cfg_data[SB-1:0];
        jac_pkg::CFG_MIN_X:    min_x    <= cfg_data[SB-1:0];
        jac_pkg::CFG_MAX_X:    max_x    <= cfg_data[SB-1:0];
        jac_pkg::CFG_MIN_Y:    min_y    <= cfg_data[SB-1:0];
        jac_pkg::CFG_MAX_Y:    max_y    <= cfg_data[SB-1:0];
        jac_pkg::CFG_ROTATION: rotation <= jac_pkg::rot_t'(cfg_data[1:0]);
        jac_pkg::CFG_DEADZONE: deadzone <= cfg_data[jac_pkg::DEADZONE_W-1:0];
        default: ;
      endcase
    end
  end

  assign raw_a[0] = raw_x;
  assign raw_a[1] = raw_y;
  assign ctr_a[0] = center_x;
  assign ctr_a[1] = center_y;
  assign lo_a[0]  = min_x;
  assign lo_a[1]  = min_y;
  assign hi_a[0]  = max_x;
  assign hi_a[1]  = max_y;

  // Classify each axis: pick the side, form numerator and divisor magnitudes.
  for (genvar k = 0; k < 2; k++) begin : g_axis
    logic          upper;
    logic [SB:0]   den;
    logic          den_neg;
    always_comb begin
      upper   = raw_a[k] >= ctr_a[k];
      den     = upper ? ({1'b0, hi_a[k]} - {1'b0, ctr_a[k]})
                      : ({1'b0, ctr_a[k]} - {1'b0, lo_a[k]});
      den_neg = den[SB];
      mag_a[k] = upper ? (raw_a[k] - ctr_a[k]) : (ctr_a[k] - raw_a[k]);
      div_a[k] = den_neg ? SB'(-den) : den[SB-1:0];
      ctl_a[k].is_zero = raw_a[k] == ctr_a[k];
      ctl_a[k].sat     = mag_a[k] >= div_a[k];
      ctl_a[k].neg     = (!upper) ^ den_neg;
    end
  end

  assign a_x   = mag_a[0];
  assign d_x   = div_a[0];
  assign ctl_x = ctl_a[0];
  assign a_y   = mag_a[1];
  assign d_y   = div_a[1];
  assign ctl_y = ctl_a[1];

endmodule

// ===== rtl/jac_queue.sv =====
`include "joystick_axis_conditioner_assert.svh"

module jac_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int AW    = jac_pkg::QUEUE_AW;
  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  `JAC_NEVER(a_count_bound, clk, rst, count > (AW+1)'(DEPTH), "queue count overflow")
  `JAC_ASSERT(a_count_step, clk, rst, (do_push && !do_pop) |=> (count != '0), "push lost")

endmodule

// ===== rtl/jac_div.sv =====
module jac_div #(
  parameter int SB = 10,
  parameter int F  = 14
) (
  input  logic               clk,
  input  logic               en,
  input  logic [SB-1:0]      a,
  input  logic [SB-1:0]      d,
  input  jac_pkg::axis_ctl_t ctl,
  output logic [F:0]         mag,
  output logic               neg
);

  localparam int NS = F + 1;

  logic [SB-1:0]      rem_s [NS+1];
  logic [SB-1:0]      dv_s  [NS+1];
  logic [F:0]         q_s   [NS+1];
  jac_pkg::axis_ctl_t ctl_s [NS+1];

  assign rem_s[0] = a;
  assign dv_s[0]  = d;
  assign q_s[0]   = '0;
  assign ctl_s[0] = ctl;

  // Restoring division, one quotient bit per stage: floor(a * 2**(F+1) / d).
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [SB:0]   sh;
    logic          take;
    logic [SB:0]   diff;
    always_comb begin
      sh   = {rem_s[i], 1'b0};
      take = sh >= {1'b0, dv_s[i]};
      diff = sh - {1'b0, dv_s[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= take ? diff[SB-1:0] : sh[SB-1:0];
        dv_s[i+1]  <= dv_s[i];
        q_s[i+1]   <= {q_s[i][F-1:0], take};
        ctl_s[i+1] <= ctl_s[i];
      end
    end
  end

  // Round half away from zero and apply the special cases.
  logic [F+1:0] q_inc;
  assign q_inc = {1'b0, q_s[NS]} + (F+2)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_s[NS].is_zero) begin
        mag <= '0;
      end else if (ctl_s[NS].sat) begin
        mag <= (F+1)'(1) << F;
      end else begin
        mag <= q_inc[F+1:1];
      end
      neg <= ctl_s[NS].neg;
    end
  end

endmodule

// ===== rtl/jac_back.sv =====
`include "joystick_axis_conditioner_assert.svh"

module jac_back #(
  parameter int SB = 10,
  parameter int F  = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic [SB-1:0]                  a_x,
  input  logic [SB-1:0]                  d_x,
  input  logic [SB-1:0]                  a_y,
  input  logic [SB-1:0]                  d_y,
  input  jac_pkg::axis_ctl_t             ctl_x,
  input  jac_pkg::axis_ctl_t             ctl_y,
  input  jac_pkg::rot_t                  rotation,
  input  logic [jac_pkg::DEADZONE_W-1:0] deadzone,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [F+1:0]            norm_x,
  output logic signed [F+1:0]            norm_y,
  output logic                           idle
);

  localparam int NW    = F + 2;
  localparam int LAT   = F + 2 + 3;
  localparam int SQ_W  = 2 * NW;
  localparam int DZ2_W = 2 * jac_pkg::DEADZONE_W;
  localparam int SUM_W = (SQ_W + 1 > DZ2_W) ? SQ_W + 1 : DZ2_W;
  localparam logic signed [NW-1:0] ONE_S = NW'(1) <<< F;

  logic           en;
  logic [LAT-1:0] vld;
  logic [F:0]     mag_x, mag_y;
  logic           neg_x, neg_y;

  logic signed [NW-1:0] sx, sy;
  logic signed [NW-1:0] rx, ry;
  logic signed [NW-1:0] x2, y2;
  logic [SQ_W-1:0]      xx, yy;
  logic [DZ2_W-1:0]     dz2;
  logic                 in_dz;

  // The whole pipe advances unless the output beat is held.
  assign en        = !vld[LAT-1] || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], q_valid};
    end
  end

  jac_div #(.SB(SB), .F(F)) u_div_x (
    .clk(clk), .en(en), .a(a_x), .d(d_x), .ctl(ctl_x), .mag(mag_x), .neg(neg_x)
  );

  jac_div #(.SB(SB), .F(F)) u_div_y (
    .clk(clk), .en(en), .a(a_y), .d(d_y), .ctl(ctl_y), .mag(mag_y), .neg(neg_y)
  );

  // Signed axes; Y is flipped so that up is positive.
  always_comb begin
    sx = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    sy = neg_y ? $signed({1'b0, mag_y}) : -$signed({1'b0, mag_y});
  end

  // Mounting rotation.
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (rotation)
        jac_pkg::ROT_CW90: begin
          rx <= sy;
          ry <= -sx;
        end
        jac_pkg::ROT_CW180: begin
          rx <= -sx;
          ry <= -sy;
        end
        jac_pkg::ROT_CW270: begin
          rx <= -sy;
          ry <= sx;
        end
        default: begin
          rx <= sx;
          ry <= sy;
        end
      endcase
    end
  end

  // Squares for the radius test, formed at full product width.
  always_ff @(posedge clk) begin
    if (en) begin
      xx  <= $unsigned(SQ_W'(rx) * SQ_W'(rx));
      yy  <= $unsigned(SQ_W'(ry) * SQ_W'(ry));
      dz2 <= deadzone * deadzone;
      x2  <= rx;
      y2  <= ry;
    end
  end

  assign in_dz = (SUM_W'(xx) + SUM_W'(yy)) < SUM_W'(dz2);

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      idle   <= in_dz;
      norm_x <= in_dz ? '0 : x2;
      norm_y <= in_dz ? '0 : y2;
    end
  end

  `JAC_ASSERT(a_idle_zero, clk, rst, (out_valid && idle) |-> (norm_x == '0 && norm_y == '0), "idle beat not zeroed")
  `JAC_NEVER(a_x_range, clk, rst, out_valid && (norm_x > ONE_S || norm_x < -ONE_S), "norm_x out of range")
  `JAC_NEVER(a_y_range, clk, rst, out_valid && (norm_y > ONE_S || norm_y < -ONE_S), "norm_y out of range")
  `JAC_ASSERT(a_pop_stall, clk, rst, (out_valid && !out_ready) |-> !q_pop, "queue popped while output held")

endmodule

// ===== test/joystick_axis_conditioner_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the conditioner.
// It keeps its own copy of the calibration, predicts one conditioned beat for
// every accepted sample beat and compares each result beat with the oldest
// prediction.
module joystick_axis_conditioner_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // raw_x, raw_y
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // norm_x, norm_y
  input  logic [31:0] m_tdata,
  // idle
  input  logic        m_tuser,
  input  logic        cfg_we,
  input  logic [jac_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [14:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam longint ONE = 64'sd1 << 14;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               idle;
  } stick_beat_t;

  // Calibration shadow.
  logic [9:0]                     cal_cx, cal_cy, cal_minx, cal_maxx, cal_miny, cal_maxy;
  jac_pkg::rot_t                  cal_rot;
  logic [jac_pkg::DEADZONE_W-1:0] cal_dz;

  stick_beat_t expected_beats[$];

  // Rounded (num * ONE) / den, halves away from zero; zero divisor saturates.
  function automatic longint scaled_quotient(longint num, longint den);
    longint n, d, q;
    if (num == 0) return 0;
    if (den == 0) return (num > 0) ? ONE : -ONE;
    n = ((num < 0) ? -num : num) << 14;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return (((num < 0) != (den < 0)) ? -q : q);
  endfunction

  // Piecewise normalization of one axis about its center.
  function automatic longint axis_deflection(logic [9:0] r, logic [9:0] c,
                                             logic [9:0] lo, logic [9:0] hi);
    longint rv, cv;
    rv = r;
    cv = c;
    if (rv >= cv) return scaled_quotient(rv - cv, longint'(hi) - cv);
    return scaled_quotient(rv - cv, cv - longint'(lo));
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic stick_beat_t condition_pair(logic [9:0] rx, logic [9:0] ry);
    stick_beat_t b;
    longint x, y, t, dz;
    x = axis_deflection(rx, cal_cx, cal_minx, cal_maxx);
    y = -axis_deflection(ry, cal_cy, cal_miny, cal_maxy);
    case (cal_rot)
      jac_pkg::ROT_CW90:  begin t = x; x = y; y = -t; end
      jac_pkg::ROT_CW180: begin x = -x; y = -y; end
      jac_pkg::ROT_CW270: begin t = x; x = -y; y = t; end
      default: ;
    endcase
    x = clamp_one(x);
    y = clamp_one(y);
    dz = cal_dz;
    b.idle = (x * x + y * y) < dz * dz;
    if (b.idle) begin
      x = 0;
      y = 0;
    end
    b.nx = x[15:0];
    b.ny = y[15:0];
    return b;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin
    stick_beat_t e;
    if (rst) begin
      cal_cx = 10'd512;
      cal_cy = 10'd512;
      cal_minx = 10'd0;
      cal_maxx = 10'd1023;
      cal_miny = 10'd0;
      cal_maxy = 10'd1023;
      cal_rot = jac_pkg::ROT_NONE;
      cal_dz = jac_pkg::DEADZONE_RESET;
      expected_beats.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_addr)
          jac_pkg::CFG_CENTER_X: cal_cx = cfg_data[9:0];
          jac_pkg::CFG_CENTER_Y: cal_cy = cfg_data[9:0];
          jac_pkg::CFG_MIN_X:    cal_minx = cfg_data[9:0];
          jac_pkg::CFG_MAX_X:    cal_maxx = cfg_data[9:0];
          jac_pkg::CFG_MIN_Y:    cal_miny = cfg_data[9:0];
          jac_pkg::CFG_MAX_Y:    cal_maxy = cfg_data[9:0];
          jac_pkg::CFG_ROTATION: cal_rot = jac_pkg::rot_t'(cfg_data[1:0]);
          jac_pkg::CFG_DEADZONE: cal_dz = cfg_data[jac_pkg::DEADZONE_W-1:0];
          default: ;
        endcase
      end
      // Sample beat in: predict its result and append it at the tail.
      if (s_tvalid && s_tready)
        expected_beats.insert(expected_beats.size(),
                              condition_pair(s_tdata[9:0], s_tdata[19:10]));
      // Result beat out: compare with the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat norm_x=%0d norm_y=%0d idle=%0b", $time,
                   $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
        end else begin
          e = expected_beats.pop_front();
          if (m_tdata[15:0] !== e.nx) begin
            errors++;
            $display("%0t: norm_x expected %0d actual %0d", $time, e.nx,
                     $signed(m_tdata[15:0]));
          end
          if (m_tdata[31:16] !== e.ny) begin
            errors++;
            $display("%0t: norm_y expected %0d actual %0d", $time, e.ny,
                     $signed(m_tdata[31:16]));
          end
          if (m_tuser !== e.idle) begin
            errors++;
            $display("%0t: idle expected %0b actual %0b", $time, e.idle, m_tuser);
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ===== test/joystick_axis_conditioner_tb.sv =====
`timescale 1ns / 1ps

module joystick_axis_conditioner_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [jac_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [14:0] cfg_data;
  int          errors;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  logic [9:0]  center_x_now, center_y_now;

  joystick_axis_conditioner u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  joystick_axis_conditioner_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous overall limit.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one sample beat, with random gaps, and returns at a falling edge.
  task automatic send_pair(input logic [9:0] rx, input logic [9:0] ry);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, ry, rx};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted beat has come out.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Writes the whole calibration, one register per cycle.
  task automatic write_calibration(input logic [9:0] cx, input logic [9:0] cy,
                                   input logic [9:0] mnx, input logic [9:0] mxx,
                                   input logic [9:0] mny, input logic [9:0] mxy,
                                   input jac_pkg::rot_t rot, input logic [14:0] dz);
    logic [14:0] vals[8];
    logic [jac_pkg::CFG_IDX_W-1:0] idx[8];
    vals = '{15'(cx), 15'(cy), 15'(mnx), 15'(mxx), 15'(mny), 15'(mxy), 15'(rot), dz};
    idx = '{jac_pkg::CFG_CENTER_X, jac_pkg::CFG_CENTER_Y, jac_pkg::CFG_MIN_X,
            jac_pkg::CFG_MAX_X, jac_pkg::CFG_MIN_Y, jac_pkg::CFG_MAX_Y,
            jac_pkg::CFG_ROTATION, jac_pkg::CFG_DEADZONE};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    center_x_now = cx;
    center_y_now = cy;
    @(negedge clk);
  endtask

  // Raw sample: near the center for deadzone edges, an extreme or the center itself, or uniform.
  function automatic logic [9:0] pick_raw(input logic [9:0] c);
    int sel, v;
    sel = $urandom_range(9);
    if (sel < 4) begin
      v = int'(c) + $urandom_range(80) - 40;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[9:0];
    end
    if (sel < 6) begin
      case ($urandom_range(2))
        0: return 10'd0;
        1: return 10'd1023;
        default: return c;
      endcase
    end
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic [14:0] pick_deadzone;
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'd16384;
      2: return 15'd32767;
      3: return jac_pkg::DEADZONE_RESET;
      default: return 15'($urandom_range(4000));
    endcase
  endfunction

  initial begin
    logic [9:0] cx, cy, mnx, mxx, mny, mxy;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = jac_pkg::CFG_CENTER_X;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    center_x_now = 10'd512;
    center_y_now = 10'd512;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset calibration, field extremes and the deadzone.
    send_pair(10'd0, 10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd512, 10'd512);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd520, 10'd505);
    send_pair(10'd512, 10'd1023);
    drain();

    // Zero divisors on both sides, cw90, and a deadzone that never trips.
    write_calibration(10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023,
                      jac_pkg::ROT_CW90, 15'd0);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd500, 10'd500);
    send_pair(10'd1023, 10'd1023);
    drain();

    // Inverted calibration, cw180, deadzone exactly one.
    write_calibration(10'd512, 10'd512, 10'd900, 10'd100, 10'd1000, 10'd20,
                      jac_pkg::ROT_CW180, 15'd16384);
    send_pair(10'd0, 10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd600, 10'd400);
    send_pair(10'd512, 10'd512);
    drain();

    // Deadzone above one, cw270, narrow calibration.
    write_calibration(10'd511, 10'd513, 10'd510, 10'd512, 10'd512, 10'd514,
                      jac_pkg::ROT_CW270, 15'd32767);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd0);
    drain();
    write_calibration(10'd300, 10'd700, 10'd10, 10'd1000, 10'd20, 10'd990,
                      jac_pkg::ROT_CW270, 15'd100);
    send_pair(10'd302, 10'd698);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd1023);
    drain();

    // Random phases, each with its own calibration and idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      cx = 10'($urandom_range(1023));
      cy = 10'($urandom_range(1023));
      if (ph == 5) begin
        mnx = 10'($urandom_range(1023));
        mxx = 10'($urandom_range(1023));
        mny = 10'($urandom_range(1023));
        mxy = 10'($urandom_range(1023));
      end else begin
        mnx = 10'($urandom_range(cx));
        mxx = 10'($urandom_range(1023, cx));
        mny = 10'($urandom_range(cy));
        mxy = 10'($urandom_range(1023, cy));
      end
      write_calibration(cx, cy, mnx, mxx, mny, mxy,
                        jac_pkg::rot_t'($urandom_range(3)), pick_deadzone());
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // Long receiver hold-off while the sender keeps offering.
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < 180; i++)
        send_pair(pick_raw(center_x_now), pick_raw(center_y_now));
      drain();
    end

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
